@@ rtl/jcc_pkg.sv @@
// ----------------------------------------------------------------------------
// jcc_pkg
// Shared widths, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package jcc_pkg;

  localparam int DEF_MAX_CHANNELS = 1024;
  localparam int DEF_SAMPLE_BITS  = 32;

  localparam int CH_W   = 10;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_USE_REFERENCE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEEP_OFFDIAG     = 3'd1;
  localparam logic [IDX_W-1:0] REG_USE_PHASE_SLOPE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_PHASE_START      = 3'd3;
  localparam logic [IDX_W-1:0] REG_PHASE_STEP       = 3'd4;

  // divider: 64-bit dividend, 30-bit divisor, 36 quotient bits
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 30;
  localparam int DIV_QW = 36;

  // square root: 60-bit radicand, 30-bit root
  localparam int SQ_NW = 60;
  localparam int SQ_RW = 30;

  // CORDIC datapath
  localparam int COR_XW    = 48;
  localparam int COR_ZW    = 36;
  localparam int COR_STEPS = 30;
  localparam int COR_IW    = 5;

  function automatic logic [COR_ZW-1:0] atan_turns(input logic [COR_IW-1:0] i);
    logic [COR_ZW-1:0] r;
    case (i)
      5'd0:  r = 36'd536870912;
      5'd1:  r = 36'd316933406;
      5'd2:  r = 36'd167458907;
      5'd3:  r = 36'd85004756;
      5'd4:  r = 36'd42667332;
      5'd5:  r = 36'd21354465;
      5'd6:  r = 36'd10679839;
      5'd7:  r = 36'd5340245;
      5'd8:  r = 36'd2670163;
      5'd9:  r = 36'd1335087;
      5'd10: r = 36'd667544;
      5'd11: r = 36'd333772;
      5'd12: r = 36'd166886;
      5'd13: r = 36'd83443;
      5'd14: r = 36'd41722;
      5'd15: r = 36'd20861;
      5'd16: r = 36'd10430;
      5'd17: r = 36'd5215;
      5'd18: r = 36'd2608;
      5'd19: r = 36'd1304;
      5'd20: r = 36'd652;
      5'd21: r = 36'd326;
      5'd22: r = 36'd163;
      5'd23: r = 36'd81;
      5'd24: r = 36'd41;
      5'd25: r = 36'd20;
      5'd26: r = 36'd10;
      5'd27: r = 36'd5;
      5'd28: r = 36'd3;
      5'd29: r = 36'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/jcc_div.sv @@
// ----------------------------------------------------------------------------
// jcc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jcc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [jcc_pkg::DIV_NW-1:0]  dividend,
  input  wire logic [jcc_pkg::DIV_DW-1:0]  divisor,
  output logic                             done,
  output logic      [jcc_pkg::DIV_QW-1:0]  quotient
);
  import jcc_pkg::*;

  logic              busy;
  logic [5:0]        cnt;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_DW-1:0] rem;
  logic [DIV_QW-1:0] low;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem, low[DIV_QW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_QW);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= DIV_DW'(dividend[DIV_NW-1:DIV_QW]);
      low <= dividend[DIV_QW-1:0];
    end else if (busy) begin
      rem      <= fits ? DIV_DW'(trial - {1'b0, dsr}) : trial[DIV_DW-1:0];
      low      <= {low[DIV_QW-2:0], 1'b0};
      quotient <= {quotient[DIV_QW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ rtl/jcc_sqrt.sv @@
// ----------------------------------------------------------------------------
// jcc_sqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jcc_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [jcc_pkg::SQ_NW-1:0]  radicand,
  output logic                            done,
  output logic      [jcc_pkg::SQ_RW-1:0]  root
);
  import jcc_pkg::*;

  logic             busy;
  logic [4:0]       cnt;
  logic [SQ_NW-1:0] src;
  logic [SQ_RW+1:0] rem;
  logic [SQ_RW+1:0] acc;
  logic [SQ_RW+1:0] trial;

  assign acc   = {rem[SQ_RW-1:0], src[SQ_NW-1:SQ_NW-2]};
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(SQ_RW - 1);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src <= {src[SQ_NW-3:0], 2'b00};
      if (acc >= trial) begin
        rem  <= acc - trial;
        root <= {root[SQ_RW-2:0], 1'b1};
      end else begin
        rem  <= acc;
        root <= {root[SQ_RW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/jcc_cordic.sv @@
// ----------------------------------------------------------------------------
// jcc_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, floor shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module jcc_cordic (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [jcc_pkg::COR_XW-1:0]  x0,
  input  wire logic signed [jcc_pkg::COR_XW-1:0]  y0,
  input  wire logic signed [jcc_pkg::COR_ZW-1:0]  z0,
  output logic                                    done,
  output logic signed      [jcc_pkg::COR_XW-1:0]  x,
  output logic signed      [jcc_pkg::COR_XW-1:0]  y
);
  import jcc_pkg::*;

  logic                     busy;
  logic [COR_IW-1:0]        i;
  logic signed [COR_ZW-1:0] z;
  logic signed [COR_XW-1:0] dx;
  logic signed [COR_XW-1:0] dy;

  assign dx = y >>> i;
  assign dy = x >>> i;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        i <= i + 5'd1;
        if (i == 5'(COR_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x0;
      y <= y0;
      z <= z0;
    end else if (busy) begin
      if (!z[COR_ZW-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - $signed(atan_turns(i));
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + $signed(atan_turns(i));
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/jones_calibration_correction_unit.sv @@
// ----------------------------------------------------------------------------
// jones_calibration_correction_unit
// Corrects 2x2 complex Jones matrices against a stored reference matrix.
// ----------------------------------------------------------------------------
// Input beats (req_valid/req_ready) carry a type, a channel and eight Q8.23
// components. A load beat stores the reference matrix when it is accepted
// and gives no result. A correct beat produces one result beat on
// rsp_valid/rsp_ready. A referenced element takes up to 28 normalising
// shifts, a 30-step square root, six multiplies and two 36-step divisions;
// a zero reference element is passed through unchanged. The phase rotation
// is a 10-step channel reduction by compare and subtract, then two 30-step
// CORDIC runs. A single multiplier, divider, root unit and CORDIC are shared
// under one sequencer; req_ready is low while it runs, so the next item is
// taken at the earliest in the cycle after the result is registered.
// The finished result sits in an output register; a new item may be taken
// while it waits, and the sequencer holds its last step until the register
// frees. Reset clears the reference matrix and sets the registers to their
// defaults (use_reference on, all else off).
// ----------------------------------------------------------------------------
`default_nettype none

module jones_calibration_correction_unit #(
  parameter int MAX_CHANNELS = jcc_pkg::DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = jcc_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic        [jcc_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic        [jcc_pkg::DATA_W-1:0] cfg_data,
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire logic                              req_type,
  input  wire logic        [jcc_pkg::CH_W-1:0]   channel,
  input  wire logic signed [jcc_pkg::DATA_W-1:0] qq_re,
  input  wire logic signed [jcc_pkg::DATA_W-1:0] qq_im,
  input  wire logic signed [jcc_pkg::DATA_W-1:0] qp_re,
  input  wire logic signed [jcc_pkg::DATA_W-1:0] qp_im,
  input  wire logic signed [jcc_pkg::DATA_W-1:0] pq_re,
  input  wire logic signed [jcc_pkg::DATA_W-1:0] pq_im,
  input  wire logic signed [jcc_pkg::DATA_W-1:0] pp_re,
  input  wire logic signed [jcc_pkg::DATA_W-1:0] pp_im,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_ready,
  output logic signed      [jcc_pkg::DATA_W-1:0] out_qq_re,
  output logic signed      [jcc_pkg::DATA_W-1:0] out_qq_im,
  output logic signed      [jcc_pkg::DATA_W-1:0] out_qp_re,
  output logic signed      [jcc_pkg::DATA_W-1:0] out_qp_im,
  output logic signed      [jcc_pkg::DATA_W-1:0] out_pq_re,
  output logic signed      [jcc_pkg::DATA_W-1:0] out_pq_im,
  output logic signed      [jcc_pkg::DATA_W-1:0] out_pp_re,
  output logic signed      [jcc_pkg::DATA_W-1:0] out_pp_im
);
  import jcc_pkg::*;

  localparam int VW       = 36;
  localparam int MW       = 36;
  localparam int SAT_BITS = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  localparam logic signed [VW-1:0] SAT_HI = (VW'(1) <<< (SAT_BITS - 1)) - VW'(1);
  localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);
  localparam logic signed [MW-1:0] KINV   = 36'sd652032874;
  localparam logic signed [2*MW-1:0] KRND = 72'sd2097152;
  localparam logic signed [COR_XW-1:0] CRND = 48'sd128;
  localparam logic [31:0] MCH = 32'(MAX_CHANNELS);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ELEM  = 5'd1;
  localparam logic [4:0] S_NORM  = 5'd2;
  localparam logic [4:0] S_SQ1   = 5'd3;
  localparam logic [4:0] S_SQ2   = 5'd4;
  localparam logic [4:0] S_SQ3   = 5'd5;
  localparam logic [4:0] S_SQW   = 5'd6;
  localparam logic [4:0] S_P1    = 5'd7;
  localparam logic [4:0] S_P2    = 5'd8;
  localparam logic [4:0] S_P3    = 5'd9;
  localparam logic [4:0] S_P4    = 5'd10;
  localparam logic [4:0] S_P5    = 5'd11;
  localparam logic [4:0] S_D1    = 5'd12;
  localparam logic [4:0] S_D1W   = 5'd13;
  localparam logic [4:0] S_D2    = 5'd14;
  localparam logic [4:0] S_D2W   = 5'd15;
  localparam logic [4:0] S_NEXT  = 5'd16;
  localparam logic [4:0] S_CROSS = 5'd17;
  localparam logic [4:0] S_CH    = 5'd18;
  localparam logic [4:0] S_CHW   = 5'd19;
  localparam logic [4:0] S_PH1   = 5'd20;
  localparam logic [4:0] S_PH2   = 5'd21;
  localparam logic [4:0] S_RQ    = 5'd22;
  localparam logic [4:0] S_RK1   = 5'd23;
  localparam logic [4:0] S_RK2   = 5'd24;
  localparam logic [4:0] S_RK3   = 5'd25;
  localparam logic [4:0] S_CW    = 5'd26;
  localparam logic [4:0] S_OUT   = 5'd27;

  logic             use_reference;
  logic             keep_offdiag;
  logic             use_phase_slope;
  logic [31:0]      phase_start;
  logic [31:0]      phase_step;

  logic signed [31:0] ref_re [4];
  logic signed [31:0] ref_im [4];

  logic [4:0]          state;
  logic [1:0]          e;
  logic [CH_W-1:0]     ch;
  logic signed [VW-1:0] vre [4];
  logic signed [VW-1:0] vim [4];

  logic [31:0]         ma;
  logic [31:0]         mb;
  logic                sa;
  logic                sb;
  logic [31:0]         mx;
  logic signed [MW-1:0] ra;
  logic signed [MW-1:0] rb;
  logic [SQ_RW-1:0]    d;
  logic signed [63:0]  acc;
  logic signed [63:0]  pr;
  logic signed [63:0]  pim;
  logic [63:0]         mag_pr;
  logic [63:0]         mag_pi;
  logic [63:0]         half_d;
  logic [CH_W-1:0]     chm;
  logic [3:0]          mk;
  logic [31:0]         phase;
  logic [1:0]          quad;
  logic [31:0]         resid;
  logic signed [VW-1:0] cx;
  logic signed [VW-1:0] cy;
  logic signed [COR_ZW-1:0] cz;
  logic signed [COR_XW-1:0] sx;
  logic signed [COR_XW-1:0] scaled;
  logic signed [VW-1:0] qs;

  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic signed [2*MW-1:0] mul_p;

  logic                div_start;
  logic [DIV_NW-1:0]   div_dvd;
  logic [DIV_DW-1:0]   div_dsr;
  logic                div_done;
  logic [DIV_QW-1:0]   div_q;

  logic                sq_start;
  logic [SQ_NW-1:0]    sq_n;
  logic                sq_done;
  logic [SQ_RW-1:0]    sq_root;

  logic                cor_start;
  logic                cor_done;
  logic signed [COR_XW-1:0] cor_x;
  logic signed [COR_XW-1:0] cor_y;

  logic                req_acc;
  logic                out_free;

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return DATA_W'(c);
  endfunction

  assign req_ready = (state == S_IDLE);
  assign req_acc   = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  assign mx     = (ma > mb) ? ma : mb;
  assign ra     = sa ? -$signed({4'b0, ma}) : $signed({4'b0, ma});
  assign rb     = sb ? -$signed({4'b0, mb}) : $signed({4'b0, mb});
  assign half_d = 64'(d >> 1);
  assign mag_pr = pr[63] ? 64'(-pr) : 64'(pr);
  assign mag_pi = pim[63] ? 64'(-pim) : 64'(pim);
  assign scaled = COR_XW'((mul_p + KRND) >>> 22);
  assign quad   = 2'(((phase + 32'h2000_0000) >> 30));
  assign resid  = phase - {quad, 30'b0};
  assign qs     = $signed({{(VW-DIV_QW){1'b0}}, div_q});

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = d;
    sq_start  = 1'b0;
    sq_n      = SQ_NW'(acc) + SQ_NW'(mul_p);
    cor_start = 1'b0;
    case (state)
      S_SQ1: begin
        mul_a = $signed({4'b0, ma});
        mul_b = $signed({4'b0, ma});
      end
      S_SQ2: begin
        mul_a = $signed({4'b0, mb});
        mul_b = $signed({4'b0, mb});
      end
      S_SQ3: sq_start = 1'b1;
      S_P1: begin
        mul_a = vre[e];
        mul_b = ra;
      end
      S_P2: begin
        mul_a = vim[e];
        mul_b = rb;
      end
      S_P3: begin
        mul_a = vim[e];
        mul_b = ra;
      end
      S_P4: begin
        mul_a = vre[e];
        mul_b = rb;
      end
      S_D1: begin
        div_start = 1'b1;
        div_dvd   = mag_pr + half_d;
      end
      S_D2: begin
        div_start = 1'b1;
        div_dvd   = mag_pi + half_d;
      end
      S_PH1: begin
        mul_a = $signed({{(MW-CH_W){1'b0}}, chm});
        mul_b = MW'($signed(phase_step));
      end
      S_RK1: begin
        mul_a = cx;
        mul_b = KINV;
      end
      S_RK2: begin
        mul_a = cy;
        mul_b = KINV;
      end
      S_RK3: cor_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_reference    <= 1'b1;
      keep_offdiag     <= 1'b0;
      use_phase_slope  <= 1'b0;
      phase_start      <= '0;
      phase_step       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_USE_REFERENCE:    use_reference    <= cfg_data[0];
        REG_KEEP_OFFDIAG:     keep_offdiag     <= cfg_data[0];
        REG_USE_PHASE_SLOPE:  use_phase_slope  <= cfg_data[0];
        REG_PHASE_START:      phase_start      <= cfg_data;
        REG_PHASE_STEP:       phase_step       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        ref_re[k] <= '0;
        ref_im[k] <= '0;
      end
    end else if (req_acc && !req_type) begin
      ref_re[0] <= qq_re;
      ref_im[0] <= qq_im;
      ref_re[1] <= qp_re;
      ref_im[1] <= qp_im;
      ref_re[2] <= pq_re;
      ref_im[2] <= pq_im;
      ref_re[3] <= pp_re;
      ref_im[3] <= pp_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      e         <= '0;
    end else begin
      if (state == S_OUT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc && req_type) begin
            e     <= '0;
            state <= use_reference ? S_ELEM : S_CROSS;
          end
        end
        S_ELEM: begin
          state <= (ref_re[e] == '0 && ref_im[e] == '0) ? S_NEXT : S_NORM;
        end
        S_NORM: begin
          if (mx >= 32'h2000_0000) begin
            state <= S_NORM;
          end else if (mx < 32'h1000_0000) begin
            state <= S_NORM;
          end else begin
            state <= S_SQ1;
          end
        end
        S_SQ1: state <= S_SQ2;
        S_SQ2: state <= S_SQ3;
        S_SQ3: state <= S_SQW;
        S_SQW: if (sq_done) state <= S_P1;
        S_P1:  state <= S_P2;
        S_P2:  state <= S_P3;
        S_P3:  state <= S_P4;
        S_P4:  state <= S_P5;
        S_P5:  state <= S_D1;
        S_D1:  state <= S_D1W;
        S_D1W: if (div_done) state <= S_D2;
        S_D2:  state <= S_D2W;
        S_D2W: if (div_done) state <= S_NEXT;
        S_NEXT: begin
          e     <= e + 2'd1;
          state <= (e == 2'd3) ? S_CROSS : S_ELEM;
        end
        S_CROSS: state <= use_phase_slope ? S_CH : S_OUT;
        S_CH:    state <= S_CHW;
        S_CHW:   if (mk == 4'd0) state <= S_PH1;
        S_PH1:   state <= S_PH2;
        S_PH2: begin
          e     <= 2'd0;
          state <= S_RQ;
        end
        S_RQ:  state <= S_RK1;
        S_RK1: state <= S_RK2;
        S_RK2: state <= S_RK3;
        S_RK3: state <= S_CW;
        S_CW: begin
          if (cor_done) begin
            if (e == 2'd0) begin
              e     <= 2'd2;
              state <= S_RQ;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ch     <= channel;
        vre[0] <= VW'(qq_re);
        vim[0] <= VW'(qq_im);
        vre[1] <= VW'(qp_re);
        vim[1] <= VW'(qp_im);
        vre[2] <= VW'(pq_re);
        vim[2] <= VW'(pq_im);
        vre[3] <= VW'(pp_re);
        vim[3] <= VW'(pp_im);
      end
      S_ELEM: begin
        ma <= ref_re[e][31] ? 32'(-ref_re[e]) : 32'(ref_re[e]);
        mb <= ref_im[e][31] ? 32'(-ref_im[e]) : 32'(ref_im[e]);
        sa <= ref_re[e][31];
        sb <= ref_im[e][31];
      end
      S_NORM: begin
        if (mx >= 32'h2000_0000) begin
          ma <= ma >> 1;
          mb <= mb >> 1;
        end else if (mx < 32'h1000_0000) begin
          ma <= ma << 1;
          mb <= mb << 1;
        end
      end
      S_SQ2: acc <= 64'(mul_p);
      S_SQW: if (sq_done) d <= sq_root;
      S_P2:  acc <= 64'(mul_p);
      S_P3:  pr  <= acc + 64'(mul_p);
      S_P4:  acc <= 64'(mul_p);
      S_P5:  pim <= acc - 64'(mul_p);
      S_D1W: if (div_done) vre[e] <= pr[63] ? -qs : qs;
      S_D2W: if (div_done) vim[e] <= pim[63] ? -qs : qs;
      S_CROSS: begin
        if (!keep_offdiag) begin
          vre[1] <= '0;
          vim[1] <= '0;
          vre[2] <= '0;
          vim[2] <= '0;
        end
      end
      S_CH: begin
        chm <= ch;
        mk  <= 4'(CH_W - 1);
      end
      // channel modulo: subtract shifted multiples, high to low
      S_CHW: begin
        if (32'(chm) >= (MCH << mk)) chm <= chm - CH_W'(MCH << mk);
        mk <= mk - 4'd1;
      end
      S_PH2: phase <= phase_start + mul_p[31:0];
      S_RQ: begin
        cz <= COR_ZW'($signed(resid));
        case (quad)
          2'd1: begin
            cx <= -vim[e];
            cy <= vre[e];
          end
          2'd2: begin
            cx <= -vre[e];
            cy <= -vim[e];
          end
          2'd3: begin
            cx <= vim[e];
            cy <= -vre[e];
          end
          default: begin
            cx <= vre[e];
            cy <= vim[e];
          end
        endcase
      end
      S_RK2: sx <= scaled;
      S_CW: begin
        if (cor_done) begin
          vre[e] <= VW'((cor_x + CRND) >>> 8);
          vim[e] <= VW'((cor_y + CRND) >>> 8);
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_qq_re <= sat(vre[0]);
          out_qq_im <= sat(vim[0]);
          out_qp_re <= sat(vre[1]);
          out_qp_im <= sat(vim[1]);
          out_pq_re <= sat(vre[2]);
          out_pq_im <= sat(vim[2]);
          out_pp_re <= sat(vre[3]);
          out_pp_im <= sat(vim[3]);
        end
      end
      default: ;
    endcase
  end

  jcc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .quotient  (div_q)
  );

  jcc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_n),
    .done     (sq_done),
    .root     (sq_root)
  );

  jcc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .x0    (sx),
    .y0    (scaled),
    .z0    (cz),
    .done  (cor_done),
    .x     (cor_x),
    .y     (cor_y)
  );

  a_load_stays_ready: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !req_type |=> req_ready)
    else $error("load beat left the sequencer busy");

  a_correct_goes_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_type |=> !req_ready)
    else $error("correct beat did not start the sequencer");

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output step");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $countones({div_start, sq_start, cor_start}) <= 1)
    else $error("two shared units started together");

endmodule

`default_nettype wire
